### sv/stepper_ramp_generator_unit_assert.svh
// assertion macros used by the stepper ramp generator controller
`ifndef STEPPER_RAMP_GENERATOR_UNIT_ASSERT_SVH
`define STEPPER_RAMP_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SRG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srg assertion failed");

// next-cycle implication
`define SRG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srg assertion failed");

`endif

### sv/srg_pkg.sv
`timescale 1ns / 1ps
package srg_pkg;

   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits  = 32;

   localparam logic [CsrIndexBits-1:0] CSR_ACCEL       = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_FIRST_IVAL  = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_MIN_IVAL    = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_POS     = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_MIN_POS     = 3'd4;
   localparam logic [CsrIndexBits-1:0] CSR_USE_LIMIT   = 3'd5;
   localparam logic [CsrIndexBits-1:0] CSR_DIR_SENSE   = 3'd6;

   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_SET_MODE   = 2'd1;
   localparam logic [1:0] OP_SET_TARGET = 2'd2;
   localparam logic [1:0] OP_LOAD_POS   = 2'd3;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_UP   = 2'd1;
   localparam logic [1:0] MODE_DOWN = 2'd2;
   localparam logic [1:0] MODE_SEEK = 2'd3;

   localparam logic [1:0] MOT_STOP = 2'd0;
   localparam logic [1:0] MOT_POS  = 2'd1;
   localparam logic [1:0] MOT_NEG  = 2'd2;

   localparam int unsigned DivBits = 64;

   typedef enum logic [1:0] {
      DIV_SPEED,
      DIV_STOP,
      DIV_TERM
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_APPLY,
      ST_SPD_GO,
      ST_SPD_WAIT,
      ST_MUL,
      ST_STOP_GO,
      ST_STOP_WAIT,
      ST_DECIDE,
      ST_TERM_GO,
      ST_TERM_WAIT,
      ST_UPDATE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic        accept;
      logic        apply;
      logic        stop_clr;
      logic        div_start;
      div_sel_type div_sel;
      logic        speed_ld;
      logic        square_ld;
      logic        stop_ld;
      logic        decide_ld;
      logic        term_ld;
      logic        update;
      logic        capture;
   } srg_cmd_type;

   typedef struct packed {
      logic op_tick;
      logic ival_zero;
      logic n_zero;
      logic div_done;
   } srg_status_type;

endpackage

### sv/srg_div.sv
`timescale 1ns / 1ps
module srg_div import srg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DivBits-1:0] dividend,
   input  logic [DivBits-1:0] divisor,
   output logic               done,
   output logic [DivBits-1:0] quotient
);

   localparam int unsigned CntBits = $clog2(DivBits);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntBits-1:0] cnt_ff;
   logic [DivBits-1:0] dvd_ff;
   logic [DivBits-1:0] dvs_ff;
   logic [DivBits-1:0] rem_ff;
   logic [DivBits:0]   shifted;
   logic [DivBits:0]   diff;
   logic               ge;

   // one restoring step per cycle, quotient bits shift into the dividend register
   always_comb begin
      shifted = {rem_ff, dvd_ff[DivBits-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && (cnt_ff == '0)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= CntBits'(DivBits - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DivBits-1:0] : shifted[DivBits-1:0];
         dvd_ff <= {dvd_ff[DivBits-2:0], ge};
         cnt_ff <= cnt_ff - CntBits'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

### sv/srg_datapath.sv
`timescale 1ns / 1ps
module srg_datapath import srg_pkg::*; #(
   parameter int unsigned POSITION_BITS          = 32,
   parameter int unsigned INTERVAL_FRACTION_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  srg_cmd_type             cmd,
   output srg_status_type          status,
   input  logic [1:0]              req_operation,
   input  logic [1:0]              req_mode,
   input  logic signed [31:0]      req_value,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_write_data,
   output logic [15:0]             rsp_step_interval,
   output logic                    rsp_step_pulse,
   output logic                    rsp_direction_level,
   output logic [1:0]              rsp_motion,
   output logic signed [31:0]      rsp_position,
   output logic                    rsp_at_max,
   output logic                    rsp_at_min
);

   localparam int unsigned PB = POSITION_BITS;
   localparam int unsigned CW = ((PB > 32) ? PB : 32) + 2;
   localparam logic [DivBits-1:0] SpeedNum = 64'd1000000 << INTERVAL_FRACTION_BITS;
   localparam logic signed [31:0] NMax = 32'sh7FFFFFFF;

   // configuration
   logic [19:0]        accel_ff;
   logic [31:0]        first_ff;
   logic [31:0]        min_ff;
   logic signed [31:0] maxp_ff;
   logic signed [31:0] minp_ff;
   logic               use_lim_ff;
   logic               sense_ff;

   // ramp state
   logic signed [PB-1:0] cur_ff, cur_in;
   logic signed [PB-1:0] tgt_ff, tgt_in;
   logic signed [31:0]   ramp_ff, ramp_in;
   logic [31:0]          ival_ff, ival_in;
   logic [1:0]           mot_ff, mot_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 dir_ff, dir_in;

   // per-item working registers
   logic [1:0]         op_ff;
   logic [1:0]         rmode_ff;
   logic signed [31:0] val_ff;
   logic [31:0]        speed_ff;
   logic [63:0]        sq_ff;
   logic [30:0]        stop_ff;
   logic signed [31:0] nw_ff;
   logic [1:0]         st_dec_ff;
   logic               dir_dec_ff;
   logic [32:0]        term_ff;

   // output register
   logic [15:0]        o_ival_ff;
   logic               o_pulse_ff;
   logic               o_dir_ff;
   logic [1:0]         o_mot_ff;
   logic signed [31:0] o_pos_ff;
   logic               o_max_ff;
   logic               o_min_ff;

   logic [DivBits-1:0] div_dvd;
   logic [DivBits-1:0] div_dvs;
   logic [DivBits-1:0] quot;
   logic               div_done;
   logic [19:0]        accel_eff;
   logic signed [34:0] dd;
   logic [34:0]        absd;
   logic signed [CW-1:0] cur_w;
   logic signed [CW-1:0] max_w;
   logic signed [CW-1:0] min_w;
   logic signed [CW-1:0] val_w;
   logic signed [CW-1:0] stop_w;
   logic signed [31:0] dec_n;
   logic [1:0]         dec_st;
   logic               dec_dir;
   logic signed [31:0] stop_s;
   logic [31:0]        sub_c;
   logic [33:0]        add_c;
   logic [31:0]        us;

   function automatic logic signed [31:0] abs_sat(input logic signed [31:0] n);
      logic signed [31:0] r;
      if (n == 32'sh80000000) r = NMax;
      else if (n < 0) r = -n;
      else r = n;
      return r;
   endfunction

   assign accel_eff = (accel_ff == '0) ? 20'd1 : accel_ff;
   assign dd        = {nw_ff[31], nw_ff, 2'b00} + 35'sd1;
   assign absd      = dd[34] ? 35'(-dd) : 35'(dd);
   assign cur_w     = CW'(cur_ff);
   assign max_w     = CW'(maxp_ff);
   assign min_w     = CW'(minp_ff);
   assign val_w     = CW'(val_ff);
   assign stop_w    = CW'({1'b0, stop_ff});
   assign stop_s    = {1'b0, stop_ff};

   always_comb begin
      unique case (cmd.div_sel)
         DIV_SPEED: begin
            div_dvd = SpeedNum;
            div_dvs = {32'b0, ival_ff};
         end
         DIV_STOP: begin
            div_dvd = sq_ff;
            div_dvs = {43'b0, accel_eff, 1'b0};
         end
         DIV_TERM: begin
            div_dvd = {31'b0, ival_ff, 1'b0};
            div_dvs = {29'b0, absd};
         end
         default: begin
            div_dvd = '0;
            div_dvs = '1;
         end
      endcase
   end

   srg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (quot)
   );

   // direction and braking decision for one tick
   always_comb begin
      dec_n   = ramp_ff;
      dec_st  = mot_ff;
      dec_dir = dir_ff;
      unique case (mode_ff)
         MODE_NONE: begin
            if (dec_st == MOT_STOP) dec_n = '0;
            else if (dec_n > 0) dec_n = (stop_ff == '0) ? -32'sd1 : -stop_s;
            else if (dec_n == 0) dec_st = MOT_STOP;
         end
         MODE_UP: begin
            if (dec_st == MOT_NEG && dec_n != 0) begin
               if (dec_n > 0) dec_n = -stop_s;
            end else begin
               dec_st = MOT_POS;
               if (dec_n < 0) dec_n = abs_sat(dec_n);
            end
         end
         MODE_DOWN: begin
            if (dec_st == MOT_POS && dec_n != 0) begin
               if (dec_n > 0) dec_n = -stop_s;
            end else begin
               dec_st = MOT_NEG;
               if (dec_n < 0) dec_n = abs_sat(dec_n);
            end
         end
         default: begin
            if (cur_ff < tgt_ff) begin
               dec_n  = abs_sat(dec_n);
               dec_st = MOT_POS;
            end else if (cur_ff > tgt_ff) begin
               dec_n  = abs_sat(dec_n);
               dec_st = MOT_NEG;
            end else begin
               dec_st = MOT_STOP;
               if (dec_n > 0) dec_n = -stop_s;
            end
         end
      endcase
      if (use_lim_ff) begin
         if (dec_st == MOT_POS) begin
            if (cur_w < max_w) begin
               if (stop_w >= max_w - cur_w && dec_n > 0) dec_n = -stop_s;
            end else begin
               dec_st = MOT_STOP;
               dec_n  = '0;
            end
         end
         if (dec_st == MOT_NEG) begin
            if (cur_w > min_w) begin
               if (stop_w >= cur_w - min_w && dec_n > 0) dec_n = -stop_s;
            end else begin
               dec_st = MOT_STOP;
               dec_n  = '0;
            end
         end
      end
      if (dec_st == MOT_POS) dec_dir = sense_ff;
      else if (dec_st == MOT_NEG) dec_dir = ~sense_ff;
      // at top speed, force deceleration
      if (ival_ff <= min_ff && dec_n > 0) dec_n = (stop_ff != '0) ? -stop_s : -32'sd1;
   end

   // state update after the recurrence term is known, or from a mode, target or position request
   always_comb begin
      cur_in  = cur_ff;
      tgt_in  = tgt_ff;
      ramp_in = ramp_ff;
      ival_in = ival_ff;
      mot_in  = mot_ff;
      mode_in = mode_ff;
      dir_in  = dir_ff;
      sub_c   = ival_ff - term_ff[31:0];
      add_c   = {2'b0, ival_ff} + {1'b0, term_ff};
      if (cmd.update) begin
         if (nw_ff == 0) begin
            ival_in = (first_ff <= min_ff) ? min_ff : first_ff;
         end else if (nw_ff > 0) begin
            ival_in = (sub_c <= min_ff) ? min_ff : sub_c;
         end else begin
            ival_in = (add_c[33:32] != 2'b00) ? 32'hFFFFFFFF : add_c[31:0];
         end
         ramp_in = (nw_ff == NMax) ? nw_ff : nw_ff + 32'sd1;
         mot_in  = st_dec_ff;
         dir_in  = dir_dec_ff;
         if (st_dec_ff == MOT_POS) cur_in = cur_ff + PB'(1);
         else if (st_dec_ff == MOT_NEG) cur_in = cur_ff - PB'(1);
      end else if (cmd.apply) begin
         unique case (op_ff)
            OP_SET_MODE: begin
               if (rmode_ff == MODE_SEEK) begin
                  tgt_in  = cur_ff;
                  ramp_in = '0;
                  mot_in  = MOT_STOP;
               end
               mode_in = rmode_ff;
            end
            OP_SET_TARGET: tgt_in = val_w[PB-1:0];
            OP_LOAD_POS:   cur_in = val_w[PB-1:0];
            default:       tgt_in = tgt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff   <= 20'd20000;
         first_ff   <= 32'd1730560;
         min_ff     <= 32'd25600;
         maxp_ff    <= '0;
         minp_ff    <= '0;
         use_lim_ff <= 1'b1;
         sense_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ACCEL:      accel_ff   <= csr_write_data[19:0];
            CSR_FIRST_IVAL: first_ff   <= csr_write_data;
            CSR_MIN_IVAL:   min_ff     <= csr_write_data;
            CSR_MAX_POS:    maxp_ff    <= csr_write_data;
            CSR_MIN_POS:    minp_ff    <= csr_write_data;
            CSR_USE_LIMIT:  use_lim_ff <= csr_write_data[0];
            CSR_DIR_SENSE:  sense_ff   <= csr_write_data[0];
            default:        sense_ff   <= sense_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         tgt_ff  <= '0;
         ramp_ff <= '0;
         ival_ff <= '0;
         mot_ff  <= MOT_STOP;
         mode_ff <= MODE_NONE;
         dir_ff  <= 1'b0;
      end else begin
         cur_ff  <= cur_in;
         tgt_ff  <= tgt_in;
         ramp_ff <= ramp_in;
         ival_ff <= ival_in;
         mot_ff  <= mot_in;
         mode_ff <= mode_in;
         dir_ff  <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_operation;
         rmode_ff <= req_mode;
         val_ff   <= req_value;
      end
      if (cmd.speed_ld) speed_ff <= (quot[63:32] != '0) ? 32'hFFFFFFFF : quot[31:0];
      if (cmd.square_ld) sq_ff <= {32'b0, speed_ff} * {32'b0, speed_ff};
      if (cmd.stop_clr) stop_ff <= '0;
      else if (cmd.stop_ld) stop_ff <= (quot[63:31] != '0) ? 31'h7FFFFFFF : quot[30:0];
      if (cmd.decide_ld) begin
         nw_ff      <= dec_n;
         st_dec_ff  <= dec_st;
         dir_dec_ff <= dec_dir;
      end
      if (cmd.term_ld) term_ff <= quot[32:0];
   end

   assign us = ival_ff >> INTERVAL_FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         o_ival_ff  <= (us >= 32'd65535) ? 16'hFFFF : us[15:0];
         o_pulse_ff <= (op_ff == OP_TICK) && (mot_ff != MOT_STOP);
         o_dir_ff   <= dir_ff;
         o_mot_ff   <= mot_ff;
         o_pos_ff   <= cur_w[31:0];
         o_max_ff   <= cur_w == max_w;
         o_min_ff   <= cur_w == min_w;
      end
   end

   assign status.op_tick   = op_ff == OP_TICK;
   assign status.ival_zero = ival_ff == '0;
   assign status.n_zero    = nw_ff == 0;
   assign status.div_done  = div_done;

   assign rsp_step_interval   = o_ival_ff;
   assign rsp_step_pulse      = o_pulse_ff;
   assign rsp_direction_level = o_dir_ff;
   assign rsp_motion          = o_mot_ff;
   assign rsp_position        = o_pos_ff;
   assign rsp_at_max          = o_max_ff;
   assign rsp_at_min          = o_min_ff;

endmodule

### sv/srg_ctrl.sv
`timescale 1ns / 1ps
`include "stepper_ramp_generator_unit_assert.svh"
module srg_ctrl import srg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  srg_status_type status,
   output srg_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           div_wait;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_SPEED;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.stop_clr = 1'b1;
            if (!status.op_tick) state_in = ST_APPLY;
            else if (status.ival_zero) state_in = ST_DECIDE;
            else state_in = ST_SPD_GO;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_DONE;
         end
         ST_SPD_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SPD_WAIT;
         end
         ST_SPD_WAIT: begin
            if (status.div_done) begin
               cmd.speed_ld = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.square_ld = 1'b1;
            state_in      = ST_STOP_GO;
         end
         ST_STOP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_STOP;
            state_in      = ST_STOP_WAIT;
         end
         ST_STOP_WAIT: begin
            cmd.div_sel = DIV_STOP;
            if (status.div_done) begin
               cmd.stop_ld = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide_ld = 1'b1;
            state_in      = ST_TERM_GO;
         end
         ST_TERM_GO: begin
            cmd.div_sel = DIV_TERM;
            // ramp restarts from the first interval, no term needed
            if (status.n_zero) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_TERM_WAIT;
            end
         end
         ST_TERM_WAIT: begin
            cmd.div_sel = DIV_TERM;
            if (status.div_done) begin
               cmd.term_ld = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.capture) rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else rsp_valid_in = 1'b0;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign div_wait  = (state_ff == ST_SPD_WAIT) || (state_ff == ST_STOP_WAIT) ||
                      (state_ff == ST_TERM_WAIT);

   `SRG_ASSERT_IMP(a_capture_free, clock, reset, cmd.capture, !rsp_valid_ff || !rsp_stall)
   `SRG_ASSERT_IMP(a_done_in_wait, clock, reset, status.div_done, div_wait)
   `SRG_ASSERT_NEXT(a_accept_check, clock, reset, cmd.accept, state_ff == ST_CHECK)

endmodule

### sv/stepper_ramp_generator_unit.sv
`timescale 1ns / 1ps
// Stepper speed-ramp generator. Each beat on req_ carries one operation and gives exactly one
// beat on rsp_. Set mode, set target and load position go through the check, apply and done
// states. A tick runs a shared restoring divider (64 restoring steps per division) up to three
// times, for the speed, the stopping distance and the recurrence term, with one 32x32 multiply
// between the first two. The term division is skipped when the ramp index restarts from zero,
// and the speed and stopping-distance divisions while the stored interval is still zero after
// reset. A stalled result in the output register holds the unit before the capture until it is
// taken; a new request is taken the cycle after the result is captured.
module stepper_ramp_generator_unit import srg_pkg::*; #(
   parameter int unsigned POSITION_BITS          = 32,
   parameter int unsigned INTERVAL_FRACTION_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [1:0]              req_mode,
   input  logic signed [31:0]      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_step_interval,
   output logic                    rsp_step_pulse,
   output logic                    rsp_direction_level,
   output logic [1:0]              rsp_motion,
   output logic signed [31:0]      rsp_position,
   output logic                    rsp_at_max,
   output logic                    rsp_at_min,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_write_data
);

   srg_cmd_type    cmd;
   srg_status_type status;

   srg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srg_datapath #(
      .POSITION_BITS          (POSITION_BITS),
      .INTERVAL_FRACTION_BITS (INTERVAL_FRACTION_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_mode            (req_mode),
      .req_value           (req_value),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_step_interval   (rsp_step_interval),
      .rsp_step_pulse      (rsp_step_pulse),
      .rsp_direction_level (rsp_direction_level),
      .rsp_motion          (rsp_motion),
      .rsp_position        (rsp_position),
      .rsp_at_max          (rsp_at_max),
      .rsp_at_min          (rsp_at_min)
   );

endmodule

### tb/tb_stepper_ramp_generator_unit.sv
`timescale 1ns / 1ps
module tb_stepper_ramp_generator_unit;
   import srg_pkg::*;

   localparam int Int32Max = 2147483647;
   localparam int IdleLimit = 20000;
   localparam int PhaseItems = 160;
   localparam int NumPhases = 8;

   typedef struct packed {
      logic [15:0] step_interval;
      logic        step_pulse;
      logic        direction_level;
      logic [1:0]  motion;
      logic [31:0] position;
      logic        at_max;
      logic        at_min;
   } ramp_status_t;

   typedef struct {
      logic [1:0]   op;
      logic [1:0]   mode;
      logic [31:0]  value;
      bit           typed;
      ramp_status_t want;
   } stim_row_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_operation;
   logic [1:0] req_mode;
   logic signed [31:0] req_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [15:0] rsp_step_interval;
   logic rsp_step_pulse;
   logic rsp_direction_level;
   logic [1:0] rsp_motion;
   logic signed [31:0] rsp_position;
   logic rsp_at_max;
   logic rsp_at_min;
   logic csr_write_enable;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0] csr_write_data;

   // predictor copy of the configuration
   logic [19:0] cfg_accel;
   logic [31:0] cfg_first_ival;
   logic [31:0] cfg_min_ival;
   logic signed [31:0] cfg_max_pos;
   logic signed [31:0] cfg_min_pos;
   logic cfg_limit_en;
   logic cfg_sense;

   // predictor copy of the motion state
   logic signed [31:0] pos_q;
   int ramp_n;
   logic [31:0] ival_q;
   logic [1:0] motion_q;
   logic [1:0] mode_q;
   logic signed [31:0] target_q;
   logic dir_q;

   ramp_status_t expected_status[$];
   stim_row_t stim_rows[$];
   int mismatches;
   int idle_cycles;
   int stall_left;
   bit quiet;

   stepper_ramp_generator_unit uut (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int stop_distance();
      longint unsigned speed, accel, q;
      if (ival_q == 0) return 0;
      speed = (64'd1000000 << 8) / ival_q;
      if (speed > 64'hFFFF_FFFF) speed = 64'hFFFF_FFFF;
      accel = (cfg_accel == 0) ? 1 : cfg_accel;
      q = (speed * speed) / (2 * accel);
      if (q > Int32Max) q = Int32Max;
      return int'(q);
   endfunction

   function automatic int abs_sat(int n);
      if (n == -Int32Max - 1) return Int32Max;
      return (n < 0) ? -n : n;
   endfunction

   function automatic bit advance_ramp();
      int stop, n;
      logic [1:0] st;
      longint unsigned cn, term;
      longint d, err;
      stop = stop_distance();
      n = ramp_n;
      st = motion_q;
      cn = ival_q;
      case (mode_q)
         MODE_NONE: begin
            if (st == MOT_STOP) n = 0;
            else if (n > 0) begin
               if (stop == 0) stop = 1;
               n = -stop;
            end else if (n == 0) st = MOT_STOP;
         end
         MODE_UP: begin
            if (st == MOT_NEG && n != 0) begin
               if (n > 0) n = -stop;
            end else begin
               st = MOT_POS;
               if (n < 0) n = abs_sat(n);
            end
         end
         MODE_DOWN: begin
            if (st == MOT_POS && n != 0) begin
               if (n > 0) n = -stop;
            end else begin
               st = MOT_NEG;
               if (n < 0) n = abs_sat(n);
            end
         end
         default: begin
            err = longint'(pos_q) - longint'(target_q);
            if (err < 0) begin
               n = abs_sat(n);
               st = MOT_POS;
            end else if (err > 0) begin
               n = abs_sat(n);
               st = MOT_NEG;
            end else begin
               st = MOT_STOP;
               if (n > 0) n = -stop;
            end
         end
      endcase
      // brake ahead of the end limits
      if (cfg_limit_en) begin
         if (st == MOT_POS) begin
            if (pos_q < cfg_max_pos) begin
               if (longint'(stop) >= longint'(cfg_max_pos) - longint'(pos_q) && n > 0)
                  n = -stop;
            end else begin
               st = MOT_STOP;
               n = 0;
            end
         end
         if (st == MOT_NEG) begin
            if (pos_q > cfg_min_pos) begin
               if (longint'(stop) >= longint'(pos_q) - longint'(cfg_min_pos) && n > 0)
                  n = -stop;
            end else begin
               st = MOT_STOP;
               n = 0;
            end
         end
      end
      if (st == MOT_POS) dir_q = cfg_sense;
      else if (st == MOT_NEG) dir_q = ~cfg_sense;
      if (n == 0) begin
         cn = (cfg_first_ival <= cfg_min_ival) ? cfg_min_ival : cfg_first_ival;
      end else begin
         if (cn <= cfg_min_ival && n > 0) n = (stop > 0) ? -stop : -1;
         d = longint'(n) * 4 + 1;
         if (d > 0) begin
            term = (2 * cn) / longint'(d);
            cn = cn - term;
         end else begin
            term = (2 * cn) / longint'(-d);
            cn = cn + term;
            if (cn > 64'hFFFF_FFFF) cn = 64'hFFFF_FFFF;
         end
         if (cn <= cfg_min_ival && n > 0) cn = cfg_min_ival;
      end
      if (n < Int32Max) n++;
      ramp_n = n;
      ival_q = cn[31:0];
      motion_q = st;
      if (st == MOT_POS) begin
         pos_q = pos_q + 1;
         return 1'b1;
      end
      if (st == MOT_NEG) begin
         pos_q = pos_q - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic ramp_status_t predict_status(logic [1:0] op, logic [1:0] mode,
                                                   logic [31:0] value);
      ramp_status_t s;
      logic pulse;
      pulse = 1'b0;
      case (op)
         OP_TICK: pulse = advance_ramp();
         OP_SET_MODE: begin
            if (mode == MODE_SEEK) begin
               target_q = pos_q;
               ramp_n = 0;
               motion_q = MOT_STOP;
            end
            mode_q = mode;
         end
         OP_SET_TARGET: target_q = value;
         default: pos_q = value;
      endcase
      s.step_interval = ((ival_q >> 8) >= 65535) ? 16'hFFFF : ival_q[23:8];
      s.step_pulse = pulse;
      s.direction_level = dir_q;
      s.motion = motion_q;
      s.position = pos_q;
      s.at_max = (pos_q == cfg_max_pos);
      s.at_min = (pos_q == cfg_min_pos);
      return s;
   endfunction

   function automatic int pick_wait();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   task automatic send_beat(logic [1:0] op, logic [1:0] mode, logic [31:0] value,
                            bit typed, ramp_status_t want);
      int gap;
      ramp_status_t got;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_mode <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      got = predict_status(op, mode, value);
      expected_status.push_back(typed ? want : got);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexBits-1:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_ACCEL: cfg_accel = data[19:0];
         CSR_FIRST_IVAL: cfg_first_ival = data;
         CSR_MIN_IVAL: cfg_min_ival = data;
         CSR_MAX_POS: cfg_max_pos = data;
         CSR_MIN_POS: cfg_min_pos = data;
         CSR_USE_LIMIT: cfg_limit_en = data[0];
         default: cfg_sense = data[0];
      endcase
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_beat();
      int r;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 72) begin
         send_beat(OP_TICK, 2'($urandom), $urandom, 1'b0, '0);
      end else if (r < 82) begin
         send_beat(OP_SET_MODE, 2'($urandom), $urandom, 1'b0, '0);
      end else if (r < 90) begin
         if ($urandom_range(0, 9) == 0) v = $urandom;
         else v = pos_q + $signed($urandom_range(0, 600)) - 300;
         send_beat(OP_SET_TARGET, 2'($urandom), v, 1'b0, '0);
      end else if (r < 95) begin
         case ($urandom_range(0, 3))
            0: v = cfg_max_pos + $signed($urandom_range(0, 20)) - 10;
            1: v = cfg_min_pos + $signed($urandom_range(0, 20)) - 10;
            2: v = 32'h7FFF_FFF8 + $urandom_range(0, 15);
            default: v = $urandom;
         endcase
         send_beat(OP_LOAD_POS, 2'($urandom), v, 1'b0, '0);
      end else begin
         // noise beat
         send_beat(2'($urandom), 2'($urandom), $urandom, 1'b0, '0);
      end
   endtask

   task automatic configure_phase(int p);
      logic [31:0] vals [7];
      case (p)
         0: vals = '{32'd1000000, 32'd512000, 32'd25600, 32'd100, -32'sd100, 1, 0};
         1: vals = '{32'd1, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1};
         2: vals = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd50, -32'sd50, 1, 1};
         3: vals = '{32'hFFFFF, 32'd1, 32'd1, 32'd200, -32'sd10, 1, 0};
         default: begin
            vals[0] = $urandom_range(1, 1000000);
            vals[1] = 256 * $urandom_range(200, 20000);
            vals[2] = 256 * $urandom_range(5, 500);
            vals[3] = $urandom_range(0, 300);
            vals[4] = -$signed($urandom_range(0, 300));
            vals[5] = (p == NumPhases - 1) ? 0 : $urandom_range(0, 1);
            vals[6] = $urandom_range(0, 1);
         end
      endcase
      write_reg(CSR_ACCEL, vals[0]);
      write_reg(CSR_FIRST_IVAL, vals[1]);
      write_reg(CSR_MIN_IVAL, vals[2]);
      write_reg(CSR_MAX_POS, vals[3]);
      write_reg(CSR_MIN_POS, vals[4]);
      write_reg(CSR_USE_LIMIT, vals[5]);
      write_reg(CSR_DIR_SENSE, vals[6]);
   endtask

   // result side: compare each beat with the oldest expectation
   always @(posedge clock) begin
      ramp_status_t seen, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_step_interval, rsp_step_pulse, rsp_direction_level, rsp_motion,
                  rsp_position, rsp_at_max, rsp_at_min};
         if (expected_status.size() == 0) begin
            $error("result beat with nothing expected");
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            if (seen.step_interval !== want.step_interval) begin
               $error("step_interval expected %0d actual %0d", want.step_interval,
                      seen.step_interval);
               mismatches++;
            end
            if (seen.step_pulse !== want.step_pulse) begin
               $error("step_pulse expected %0d actual %0d", want.step_pulse, seen.step_pulse);
               mismatches++;
            end
            if (seen.direction_level !== want.direction_level) begin
               $error("direction_level expected %0d actual %0d", want.direction_level,
                      seen.direction_level);
               mismatches++;
            end
            if (seen.motion !== want.motion) begin
               $error("motion expected %0d actual %0d", want.motion, seen.motion);
               mismatches++;
            end
            if (seen.position !== want.position) begin
               $error("position expected %0d actual %0d", $signed(want.position),
                      $signed(seen.position));
               mismatches++;
            end
            if (seen.at_max !== want.at_max) begin
               $error("at_max expected %0d actual %0d", want.at_max, seen.at_max);
               mismatches++;
            end
            if (seen.at_min !== want.at_min) begin
               $error("at_min expected %0d actual %0d", want.at_min, seen.at_min);
               mismatches++;
            end
         end
      end
   end

   // receiver stalls: mostly short, a few long, none while quiet
   always @(posedge clock) begin
      int r;
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 80);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      ramp_status_t none;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_TICK;
      req_mode = MODE_NONE;
      req_value = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mismatches = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      cfg_accel = 20000;
      cfg_first_ival = 1730560;
      cfg_min_ival = 25600;
      cfg_max_pos = 0;
      cfg_min_pos = 0;
      cfg_limit_en = 1'b1;
      cfg_sense = 1'b0;
      pos_q = 0;
      ramp_n = 0;
      ival_q = 0;
      motion_q = MOT_STOP;
      mode_q = MODE_NONE;
      target_q = 0;
      dir_q = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows, reset configuration: limits at zero and enabled
      stim_rows = '{
         '{OP_SET_TARGET, MODE_SEEK, 32'd0, 1, '{16'd0, 0, 0, MOT_STOP, 32'd0, 1, 1}},
         '{OP_LOAD_POS, MODE_UP, 32'h7FFF_FFFF, 1,
           '{16'd0, 0, 0, MOT_STOP, 32'h7FFF_FFFF, 0, 0}},
         '{OP_LOAD_POS, MODE_DOWN, 32'h8000_0000, 1,
           '{16'd0, 0, 0, MOT_STOP, 32'h8000_0000, 0, 0}},
         '{OP_LOAD_POS, MODE_NONE, 32'd0, 1, '{16'd0, 0, 0, MOT_STOP, 32'd0, 1, 1}},
         '{OP_SET_MODE, MODE_UP, 32'hFFFF_FFFF, 1, '{16'd0, 0, 0, MOT_STOP, 32'd0, 1, 1}},
         // run up blocked at the upper limit
         '{OP_TICK, MODE_DOWN, 32'd0, 1, '{16'd6760, 0, 0, MOT_STOP, 32'd0, 1, 1}},
         '{OP_SET_MODE, MODE_DOWN, 32'd0, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_LOAD_POS, MODE_SEEK, -32'sd40, 0, none},
         '{OP_SET_MODE, MODE_UP, 32'd0, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_TICK, MODE_SEEK, 32'd0, 0, none},
         '{OP_SET_MODE, MODE_NONE, 32'd0, 0, none},
         '{OP_TICK, MODE_UP, 32'd0, 0, none},
         '{OP_TICK, MODE_UP, 32'd0, 0, none},
         '{OP_SET_MODE, MODE_SEEK, 32'd0, 0, none},
         '{OP_SET_TARGET, MODE_NONE, -32'sd45, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_SET_TARGET, MODE_NONE, 32'h8000_0000, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_SET_MODE, MODE_DOWN, 32'd0, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none},
         '{OP_TICK, MODE_NONE, 32'd0, 0, none}
      };
      foreach (stim_rows[i])
         send_beat(stim_rows[i].op, stim_rows[i].mode, stim_rows[i].value,
                   stim_rows[i].typed, stim_rows[i].want);

      for (int p = 0; p < NumPhases; p++) begin
         drain();
         configure_phase(p);
         quiet = (p % 3 == 1);
         send_beat(OP_SET_MODE, MODE_SEEK, 32'd0, 1'b0, '0);
         for (int i = 0; i < PhaseItems; i++)
            random_beat();
      end
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
